// ===== rtl/core/spidiv_pkg.sv =====
`timescale 1ns / 1ps

package spidiv_pkg;

    localparam int SRC_W  = 31;
    localparam int REQ_W  = 32;
    localparam int WORD_W = 32;

    localparam int PRESCALE_BITS_DEF = 13;
    localparam int N_BITS_DEF        = 6;

    // packed word layout
    localparam int LO_W      = 6;
    localparam int N_FW      = 6;
    localparam int PRE_FW    = 13;
    localparam int N_SHIFT   = 12;
    localparam int PRE_SHIFT = 18;

    localparam logic [SRC_W-1:0]  SRC_RESET   = 31'd80000000;
    localparam logic [WORD_W-1:0] BYPASS_WORD = 32'h8000_0000;

    typedef struct packed {
        logic             start;
        logic [SRC_W-1:0] dividend;
        logic [REQ_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SRC_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } srch_res_t;

endpackage

// ===== rtl/core/spidiv_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module spidiv_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spidiv_pkg::div_cmd_t div_cmd,
    output spidiv_pkg::div_rsp_t div_rsp
);
    import spidiv_pkg::*;

    localparam int CNT_W = $clog2(SRC_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REQ_W-1:0] rem_reg, rem_next;
    logic [SRC_W-1:0] dq_reg, dq_next;
    logic [REQ_W-1:0] dsr_reg, dsr_next;

    logic [REQ_W:0] trial;
    logic [REQ_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, dq_reg[SRC_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = !diff[REQ_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dsr_next  = dsr_reg;
        if (div_cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SRC_W - 1);
            rem_next  = '0;
            dq_next   = div_cmd.dividend;
            dsr_next  = div_cmd.divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            rem_next = ge ? diff[REQ_W-1:0] : trial[REQ_W-1:0];
            dq_next  = {dq_reg[SRC_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dsr_reg <= dsr_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = dq_reg;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !busy_reg)
        else $error("divider started while busy");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !div_cmd.start && cnt_reg == '0 |=> done_reg && !busy_reg)
        else $error("divider missed done after last step");
`endif

endmodule

// ===== rtl/core/spidiv_search.sv =====
`timescale 1ns / 1ps

// Sequencer for the prescaler / divider search; uses one shared divider.
module spidiv_search #(
    parameter int PRESCALE_BITS = spidiv_pkg::PRESCALE_BITS_DEF,
    parameter int N_BITS        = spidiv_pkg::N_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spidiv_pkg::REQ_W-1:0]      req,
    input  logic [spidiv_pkg::SRC_W-1:0]      src,
    output spidiv_pkg::div_cmd_t              div_cmd,
    input  spidiv_pkg::div_rsp_t              div_rsp,
    output spidiv_pkg::srch_res_t             res,
    input  logic                              res_take
);
    import spidiv_pkg::*;

    localparam int MIN_SHIFT = PRESCALE_BITS + N_BITS;
    localparam int PROD_W    = PRESCALE_BITS + N_BITS + 1;
    localparam logic [PRESCALE_BITS-1:0] PRE_MAX = '1;
    localparam logic [N_BITS-1:0]        N_MAX   = '1;
    localparam logic [1:0]               V_LAST  = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV1 = 7'b0000010,
        S_DIV2 = 7'b0000100,
        S_PRE  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_CAND = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    function automatic logic [WORD_W-1:0] pack_word(
        input logic [PRESCALE_BITS-1:0] pre,
        input logic [N_BITS-1:0]        n
    );
        logic [WORD_W-1:0] w;
        logic [N_BITS:0]   half;
        w    = '0;
        half = ({1'b0, n} + (N_BITS+1)'(1)) >> 1;
        w[LO_W-1:0]            = LO_W'(half);
        w[N_SHIFT +: N_FW]     = N_FW'(n);
        w[PRE_SHIFT +: PRE_FW] = PRE_FW'(pre);
        return w;
    endfunction

    localparam logic [WORD_W-1:0] SLOW_WORD = pack_word(PRE_MAX, N_MAX) & ~WORD_W'(LO_W'('1));

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         req_reg, req_next;
    logic [N_BITS-1:0]        n_reg, n_next;
    logic [1:0]               v_reg, v_next;
    logic [SRC_W-1:0]         q_reg, q_next;
    logic [PRESCALE_BITS-1:0] pre_reg, pre_next;
    logic [SRC_W-1:0]         best_f_reg, best_f_next;
    logic [WORD_W-1:0]        best_word_reg, best_word_next;
    logic [WORD_W-1:0]        word_reg, word_next;
    div_cmd_t                 cmd_reg, cmd_next;

    logic [SRC_W-1:0]         min_f;
    logic [REQ_W-1:0]         q_plus;
    logic [REQ_W-1:0]         q_off;
    logic [PRESCALE_BITS-1:0] pre_clamp;
    logic [PROD_W-1:0]        prod;
    logic [N_BITS-1:0]        n_inc;
    logic [SRC_W-1:0]         f;

    assign min_f = src >> MIN_SHIFT;
    assign f     = div_rsp.quotient;
    assign n_inc = n_reg + N_BITS'(1);

    // offset code 0..3 stands for -2..+1 around the estimate
    assign q_plus = {1'b0, q_reg} + REQ_W'(v_reg);
    assign q_off  = q_plus - REQ_W'(2);

    always_comb
    begin
        priority if (q_plus <= REQ_W'(2))
            pre_clamp = '0;
        else if (q_off > REQ_W'(PRE_MAX))
            pre_clamp = PRE_MAX;
        else
            pre_clamp = q_off[PRESCALE_BITS-1:0];
    end

    assign prod = PROD_W'({1'b0, pre_reg} + (PRESCALE_BITS+1)'(1))
                * PROD_W'({1'b0, n_reg} + (N_BITS+1)'(1));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        q_next         = q_reg;
        pre_next       = pre_reg;
        best_f_next    = best_f_reg;
        best_word_next = best_word_reg;
        word_next      = word_reg;
        cmd_next       = cmd_reg;
        cmd_next.start = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req;
                    priority if (req >= {1'b0, src})
                    begin
                        word_next  = BYPASS_WORD;
                        state_next = S_DONE;
                    end
                    else if (req < {1'b0, min_f} || req == '0)
                    begin
                        word_next  = SLOW_WORD;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        n_next           = N_BITS'(1);
                        best_f_next      = '0;
                        best_word_next   = '0;
                        cmd_next.start    = 1'b1;
                        cmd_next.dividend = src;
                        cmd_next.divisor  = REQ_W'(2);
                        state_next       = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    cmd_next.start    = 1'b1;
                    cmd_next.dividend = div_rsp.quotient;
                    cmd_next.divisor  = req_reg;
                    state_next        = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient;
                    v_next     = '0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                pre_next   = pre_clamp;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd_next.start    = 1'b1;
                cmd_next.dividend = src;
                cmd_next.divisor  = REQ_W'(prod);
                state_next        = S_CAND;
            end
            S_CAND:
            begin
                if (div_rsp.done)
                begin
                    if ({1'b0, f} == req_reg)
                    begin
                        word_next  = pack_word(pre_reg, n_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // strictly greater: first candidate keeps a tie
                        if ({1'b0, f} < req_reg && f > best_f_reg)
                        begin
                            best_f_next    = f;
                            best_word_next = pack_word(pre_reg, n_reg);
                        end
                        if (v_reg == V_LAST)
                        begin
                            if (n_reg == N_MAX)
                            begin
                                word_next  = best_word_next;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                n_next            = n_inc;
                                cmd_next.start    = 1'b1;
                                cmd_next.dividend = src;
                                cmd_next.divisor  = REQ_W'(n_inc) + REQ_W'(1);
                                state_next        = S_DIV1;
                            end
                        end
                        else
                        begin
                            v_next     = v_reg + 2'd1;
                            state_next = S_PRE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        n_reg            <= n_next;
        v_reg            <= v_next;
        q_reg            <= q_next;
        pre_reg          <= pre_next;
        best_f_reg       <= best_f_next;
        best_word_reg    <= best_word_next;
        word_reg         <= word_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign div_cmd   = cmd_reg;
    assign res.valid = (state_reg == S_DONE);
    assign res.word  = word_reg;

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("search stayed idle after accepting an item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res_take |=> res.valid && $stable(res.word))
        else $error("search result changed before it was taken");

    a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAND || state_reg == S_MUL) |-> n_reg != '0)
        else $error("divider index zero during search");
`endif

endmodule

// ===== rtl/core/spi_clock_divider_search.sv =====
`timescale 1ns / 1ps

// SPI clock divider search.
// Input channel (in_valid / in_ready, requested_hz) takes one requested SPI
// clock per item; output channel (out_valid / out_ready, divider_word,
// sysclk_select) returns one packed divider word per item, in order.
// cfg_write / cfg_data load the source clock in hertz; write only when idle.
// Bypass and slowest-setting cases skip the divider; their result passes
// through the searcher's result register into the output register.
// A full search runs one shared restoring divider, one quotient bit per
// cycle; each divider value n costs two divisions for the prescale
// estimate plus four trial divisions, and the worst case tries every n.
// An exact match ends the search early.
// One item is searched at a time; a new item is accepted as soon as the
// searcher is free, even while the previous result waits in the output
// register. If the receiver stalls, the result holds in the output register
// and the searcher holds its next finished result until the register frees.
// Reset clears both channels and sets the source clock to 80 MHz.
module spi_clock_divider_search #(
    parameter int PRESCALE_BITS = spidiv_pkg::PRESCALE_BITS_DEF,
    parameter int N_BITS        = spidiv_pkg::N_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [spidiv_pkg::SRC_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [spidiv_pkg::REQ_W-1:0]      requested_hz,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [spidiv_pkg::WORD_W-1:0]     divider_word,
    output logic                              sysclk_select
);
    import spidiv_pkg::*;

    logic [SRC_W-1:0]  src_reg, src_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              sel_reg, sel_next;

    div_cmd_t  div_cmd;
    div_rsp_t  div_rsp;
    srch_res_t res;
    logic      res_take;

    spidiv_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_cmd (div_cmd),
        .div_rsp (div_rsp)
    );

    spidiv_search #(
        .PRESCALE_BITS (PRESCALE_BITS),
        .N_BITS        (N_BITS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req      (requested_hz),
        .src      (src_reg),
        .div_cmd  (div_cmd),
        .div_rsp  (div_rsp),
        .res      (res),
        .res_take (res_take)
    );

    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        src_next       = cfg_write ? cfg_data : src_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        sel_next       = sel_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            word_next      = res.word;
            sel_next       = (res.word == BYPASS_WORD);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg       <= SRC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        sel_reg  <= sel_next;
    end

    assign out_valid     = out_valid_reg;
    assign divider_word  = word_reg;
    assign sysclk_select = sel_reg;

endmodule
